// ===== hdl/dalm_pkg.sv =====
package dalm_pkg;

    // Table sizes; both are 16, which sets the 4-bit thread and resource fields
    localparam int THREAD_COUNT   = 16;
    localparam int RESOURCE_COUNT = 16;
    localparam int TW = $clog2(THREAD_COUNT);
    localparam int RW = $clog2(RESOURCE_COUNT);
    localparam int CW = 5;

    // Command codes
    localparam logic CMD_WAIT = 1'b0;
    localparam logic CMD_POST = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_GRANTED        = 3'd0;
    localparam logic [2:0] ST_BLOCKED        = 3'd1;
    localparam logic [2:0] ST_OWNER          = 3'd2;
    localparam logic [2:0] ST_DEADLOCK       = 3'd3;
    localparam logic [2:0] ST_POST_DONE      = 3'd4;
    localparam logic [2:0] ST_POST_UNKNOWN   = 3'd5;
    localparam logic [2:0] ST_THREAD_BLOCKED = 3'd6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_SCAN
    } seq_state_t;

    typedef struct packed {
        logic          command;
        logic [TW-1:0] thread;
        logic [RW-1:0] resource;
    } req_item_t;

    typedef struct packed {
        logic [2:0]    status;
        logic          woken_valid;
        logic [TW-1:0] woken_thread;
    } rsp_item_t;

    // Table read addresses
    typedef struct packed {
        logic [RW-1:0] own_addr;
        logic [TW-1:0] wait_addr;
    } tbl_addr_t;

    // Table read data
    typedef struct packed {
        logic          own_valid;
        logic [TW-1:0] own_thread;
        logic          wait_valid;
        logic [RW-1:0] wait_res;
        logic          known;
    } tbl_rd_t;

    // Table write controls
    typedef struct packed {
        logic          own_we;
        logic [RW-1:0] own_addr;
        logic          own_valid;
        logic [TW-1:0] own_thread;
        logic          wait_we;
        logic [TW-1:0] wait_addr;
        logic          wait_valid;
        logic [RW-1:0] wait_res;
        logic          known_we;
        logic [TW-1:0] known_addr;
    } tbl_wr_t;

endpackage

// ===== hdl/dalm_tables.sv =====
module dalm_tables
    import dalm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  tbl_addr_t addr,
    input  tbl_wr_t   wr,
    output tbl_rd_t   rd
);

    logic          own_valid_reg  [RESOURCE_COUNT];
    logic [TW-1:0] own_thread_reg [RESOURCE_COUNT];
    logic          wait_valid_reg [THREAD_COUNT];
    logic [RW-1:0] wait_res_reg   [THREAD_COUNT];
    logic          known_reg      [THREAD_COUNT];

    // Valid and known bits clear on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RESOURCE_COUNT; i++)
            begin
                own_valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < THREAD_COUNT; i++)
            begin
                wait_valid_reg[i] <= 1'b0;
                known_reg[i]      <= 1'b0;
            end
        end
        else
        begin
            if (wr.own_we)
            begin
                own_valid_reg[wr.own_addr] <= wr.own_valid;
            end
            if (wr.wait_we)
            begin
                wait_valid_reg[wr.wait_addr] <= wr.wait_valid;
            end
            if (wr.known_we)
            begin
                known_reg[wr.known_addr] <= 1'b1;
            end
        end
    end

    // Payload entries, meaningful only under their valid bit
    always_ff @(posedge clk)
    begin
        if (wr.own_we)
        begin
            own_thread_reg[wr.own_addr] <= wr.own_thread;
        end
        if (wr.wait_we)
        begin
            wait_res_reg[wr.wait_addr] <= wr.wait_res;
        end
    end

    // One read address per table
    always_comb
    begin
        rd.own_valid  = own_valid_reg[addr.own_addr];
        rd.own_thread = own_thread_reg[addr.own_addr];
        rd.wait_valid = wait_valid_reg[addr.wait_addr];
        rd.wait_res   = wait_res_reg[addr.wait_addr];
        rd.known      = known_reg[addr.wait_addr];
    end

endmodule

// ===== hdl/deadlock_avoiding_lock_manager.sv =====
// Channel   Handshake                   Payload
// request   start, busy                 req (command, thread, resource)
// result    done (one-cycle strobe)     rsp (status, woken_valid, woken_thread)
// config    cfg_valid, cfg_ready        cfg_data (resources_in_use)
//
// A request does one lookup, then for a contended wait walks the owner/wait
// chain one link per cycle (up to 16 links), or for a releasing post scans
// one thread per cycle for a waiter (up to 16 threads). The single compare
// path over the thread tables sets this pace. done pulses in the same cycle
// that busy falls. No clearing pass: tables are ready right after reset. The
// result cannot be stalled; busy only reflects the request in progress.
module deadlock_avoiding_lock_manager
    import dalm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  req_item_t     req,
    output logic          done,
    output rsp_item_t     rsp,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [CW-1:0] cfg_data
);

    localparam logic [TW-1:0] T_LAST = TW'(THREAD_COUNT - 1);
    localparam logic [CW-1:0] RC_LIM = CW'(RESOURCE_COUNT);

    seq_state_t    state_reg, state_next;
    logic          cmd_reg;
    logic [TW-1:0] thr_reg;
    logic [RW-1:0] res_reg;
    logic [TW-1:0] cur_reg, cur_next;
    logic [TW-1:0] step_reg, step_next;
    logic [CW-1:0] riu_reg;
    logic          done_reg;
    rsp_item_t     rsp_reg, rsp_next;
    logic          finish;
    logic          res_ok;

    tbl_addr_t tbl_addr;
    tbl_wr_t   tbl_wr;
    tbl_rd_t   tbl_rd;

    dalm_tables u_tables (
        .clk   (clk),
        .rst_n (rst_n),
        .addr  (tbl_addr),
        .wr    (tbl_wr),
        .rd    (tbl_rd)
    );

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign rsp       = rsp_reg;

    assign res_ok = ({1'b0, res_reg} < riu_reg) && ({1'b0, res_reg} < RC_LIM);

    // Table addressing: chain walk reads the owner of the resource waited on
    always_comb
    begin
        tbl_addr.wait_addr = (state_reg == S_CHECK) ? thr_reg : cur_reg;
        tbl_addr.own_addr  = (state_reg == S_WALK) ? tbl_rd.wait_res : res_reg;
    end

    // Sequencer and compare unit
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        step_next  = step_reg;
        finish     = 1'b0;
        rsp_next   = '0;
        tbl_wr     = '0;
        tbl_wr.known_addr = thr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (cmd_reg == CMD_WAIT)
                begin
                    tbl_wr.known_we = 1'b1;
                    priority if (!res_ok)
                    begin
                        finish          = 1'b1;
                        rsp_next.status = ST_DEADLOCK;
                    end
                    else if (tbl_rd.own_valid && tbl_rd.own_thread == thr_reg)
                    begin
                        finish          = 1'b1;
                        rsp_next.status = ST_OWNER;
                    end
                    else if (tbl_rd.wait_valid)
                    begin
                        finish          = 1'b1;
                        rsp_next.status = ST_THREAD_BLOCKED;
                    end
                    else if (!tbl_rd.own_valid)
                    begin
                        finish            = 1'b1;
                        rsp_next.status   = ST_GRANTED;
                        tbl_wr.own_we     = 1'b1;
                        tbl_wr.own_addr   = res_reg;
                        tbl_wr.own_valid  = 1'b1;
                        tbl_wr.own_thread = thr_reg;
                    end
                    else
                    begin
                        cur_next   = tbl_rd.own_thread;
                        step_next  = '0;
                        state_next = S_WALK;
                    end
                end
                else
                begin
                    priority if (!tbl_rd.known || !res_ok)
                    begin
                        finish          = 1'b1;
                        rsp_next.status = ST_POST_UNKNOWN;
                    end
                    else if (tbl_rd.own_valid && tbl_rd.own_thread == thr_reg)
                    begin
                        cur_next   = '0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        finish          = 1'b1;
                        rsp_next.status = ST_POST_DONE;
                    end
                end
            end

            // One owner/wait link per cycle
            S_WALK:
            begin
                priority if (cur_reg == thr_reg)
                begin
                    finish          = 1'b1;
                    rsp_next.status = ST_DEADLOCK;
                end
                else if (!tbl_rd.wait_valid || !tbl_rd.own_valid || step_reg == T_LAST)
                begin
                    finish            = 1'b1;
                    rsp_next.status   = ST_BLOCKED;
                    tbl_wr.wait_we    = 1'b1;
                    tbl_wr.wait_addr  = thr_reg;
                    tbl_wr.wait_valid = 1'b1;
                    tbl_wr.wait_res   = res_reg;
                end
                else
                begin
                    cur_next  = tbl_rd.own_thread;
                    step_next = step_reg + 1'b1;
                end
            end

            // Lowest-numbered waiter on the released resource takes it
            S_SCAN:
            begin
                tbl_wr.own_addr = res_reg;
                priority if (tbl_rd.wait_valid && tbl_rd.wait_res == res_reg)
                begin
                    finish                = 1'b1;
                    rsp_next.status       = ST_POST_DONE;
                    rsp_next.woken_valid  = 1'b1;
                    rsp_next.woken_thread = cur_reg;
                    tbl_wr.wait_we        = 1'b1;
                    tbl_wr.wait_addr      = cur_reg;
                    tbl_wr.own_we         = 1'b1;
                    tbl_wr.own_valid      = 1'b1;
                    tbl_wr.own_thread     = cur_reg;
                end
                else if (cur_reg == T_LAST)
                begin
                    finish          = 1'b1;
                    rsp_next.status = ST_POST_DONE;
                    tbl_wr.own_we   = 1'b1;
                end
                else
                begin
                    cur_next = cur_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next = S_IDLE;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            riu_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finish;
            if (cfg_valid && cfg_ready)
            begin
                riu_reg <= cfg_data;
            end
        end
    end

    // Request capture, walk cursor and result
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= req.command;
            thr_reg <= req.thread;
            res_reg <= req.resource;
        end
        cur_reg  <= cur_next;
        step_reg <= step_next;
        if (finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Every completed request strobes its result in the same cycle that busy drops
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a result strobe");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_woken_post: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.woken_valid |-> rsp.status == ST_POST_DONE)
        else $error("woken thread on a result other than post done");

    a_woken_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !rsp.woken_valid |-> rsp.woken_thread == '0)
        else $error("woken thread nonzero without woken_valid");

endmodule
